// ===== hdl/hmc_pkg.sv =====
`timescale 1ns / 1ps

package hmc_pkg;

  // APB configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register index, taken from paddr[2]
  localparam logic REG_MIN_TEMP = 1'b0;
  localparam logic REG_MAX_TEMP = 1'b1;

  // Reset value of max_temp (100.0 with 8 fraction bits)
  localparam logic [31:0] MAX_TEMP_RESET = 32'd25600;

  // Color channels
  localparam int CHAN_W = 8;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;
  localparam logic [CHAN_W-1:0] CHAN_MIN = 8'h00;

  // Heat scale triangles, centered at (index + 1) sixths
  localparam int NUM_TRI   = 6;
  localparam int TRI_BLUE  = 0;
  localparam int TRI_CYAN  = 1;
  localparam int TRI_GREEN = 2;
  localparam int TRI_YEL   = 3;
  localparam int TRI_RED   = 4;
  localparam int TRI_WHITE = 5;

  // Range classification of a sample
  typedef struct packed {
    logic below;  // sample under min_temp: black
    logic white;  // sample over max_temp or empty range: white
  } cls_t;

endpackage

// ===== hdl/hmc_sample_if.sv =====
`timescale 1ns / 1ps

interface hmc_sample_if #(
  parameter int TEMP_WIDTH = 24
) ();
  logic                         valid;
  logic                         ready;
  logic signed [TEMP_WIDTH-1:0] temp_sample;

  modport source (output valid, output temp_sample, input ready);
  modport sink   (input valid, input temp_sample, output ready);
endinterface

// ===== hdl/hmc_color_if.sv =====
`timescale 1ns / 1ps

interface hmc_color_if ();
  logic                        valid;
  logic                        ready;
  logic [hmc_pkg::CHAN_W-1:0] red_level;
  logic [hmc_pkg::CHAN_W-1:0] green_level;
  logic [hmc_pkg::CHAN_W-1:0] blue_level;

  modport source (output valid, output red_level, output green_level, output blue_level,
                  input ready);
  modport sink   (input valid, input red_level, input green_level, input blue_level,
                  output ready);
endinterface

// ===== hdl/hmc_cfg.sv =====
`timescale 1ns / 1ps

module hmc_cfg #(
  parameter int TEMP_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hmc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [hmc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [hmc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic signed [TEMP_WIDTH-1:0]      min_temp,
  output logic signed [TEMP_WIDTH-1:0]      max_temp,
  output logic [TEMP_WIDTH-1:0]             span,
  output logic                              empty
);

  localparam logic signed [TEMP_WIDTH-1:0] MAX_RST = hmc_pkg::MAX_TEMP_RESET[TEMP_WIDTH-1:0];

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_temp <= '0;
      max_temp <= MAX_RST;
    end else if (wr_en) begin
      case (reg_idx)
        hmc_pkg::REG_MIN_TEMP: min_temp <= pwdata[TEMP_WIDTH-1:0];
        hmc_pkg::REG_MAX_TEMP: max_temp <= pwdata[TEMP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Divisor and empty-range flag, registered from max_temp and min_temp
  always_ff @(posedge clk) begin
    if (rst) begin
      span  <= MAX_RST;
      empty <= (MAX_RST <= 0);
    end else begin
      span  <= $unsigned(max_temp - min_temp);
      empty <= (max_temp <= min_temp);
    end
  end

  always_comb begin
    case (reg_idx)
      hmc_pkg::REG_MIN_TEMP: prdata = hmc_pkg::APB_DATA_W'($unsigned(min_temp));
      hmc_pkg::REG_MAX_TEMP: prdata = hmc_pkg::APB_DATA_W'($unsigned(max_temp));
      default:               prdata = '0;
    endcase
  end

endmodule

// ===== hdl/hmc_front.sv =====
`timescale 1ns / 1ps

module hmc_front #(
  parameter int TEMP_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [TEMP_WIDTH-1:0]  temp_sample,
  input  logic signed [TEMP_WIDTH-1:0]  min_temp,
  input  logic signed [TEMP_WIDTH-1:0]  max_temp,
  input  logic                          empty,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hmc_pkg::cls_t                 out_cls,
  output logic [TEMP_WIDTH-1:0]         out_diff
);

  logic                         s0_valid;
  logic                         s0_ready;
  logic signed [TEMP_WIDTH-1:0] t0;
  logic                         s1_ready;

  assign s1_ready = !out_valid || out_ready;
  assign s0_ready = !s0_valid || s1_ready;
  assign in_ready = s0_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s0_ready) s0_valid <= in_valid;
      if (s1_ready) out_valid <= s0_valid;
    end
  end

  // Capture the sample
  always_ff @(posedge clk) begin
    if (s0_ready && in_valid) t0 <= temp_sample;
  end

  // Classify and form the dividend; t - min fits TEMP_WIDTH bits when in range
  always_ff @(posedge clk) begin
    if (s1_ready && s0_valid) begin
      out_cls.below <= (t0 < min_temp);
      out_cls.white <= (t0 > max_temp) || empty;
      out_diff      <= $unsigned(t0 - min_temp);
    end
  end

endmodule

// ===== hdl/hmc_div_stage.sv =====
`timescale 1ns / 1ps

module hmc_div_stage #(
  parameter int TEMP_WIDTH = 24,
  parameter int QW         = 17,
  parameter bit FIRST      = 1'b0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hmc_pkg::cls_t         in_cls,
  input  logic [TEMP_WIDTH-1:0] in_rem,
  input  logic [QW-1:0]         in_quo,
  input  logic [TEMP_WIDTH-1:0] span,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hmc_pkg::cls_t         out_cls,
  output logic [TEMP_WIDTH-1:0] out_rem,
  output logic [QW-1:0]         out_quo
);

  logic [TEMP_WIDTH:0] part;
  logic [TEMP_WIDTH:0] diff;
  logic                ge;

  // First stage takes the dividend as is, later ones the doubled remainder
  assign part     = FIRST ? {1'b0, in_rem} : {in_rem, 1'b0};
  assign diff     = part - {1'b0, span};
  assign ge       = (part >= {1'b0, span});
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_cls <= in_cls;
      out_rem <= ge ? diff[TEMP_WIDTH-1:0] : part[TEMP_WIDTH-1:0];
      out_quo <= {in_quo[QW-2:0], ge};
    end
  end

endmodule

// ===== hdl/hmc_shade.sv =====
`timescale 1ns / 1ps

module hmc_shade #(
  parameter int POS_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  hmc_pkg::cls_t               in_cls,
  input  logic [POS_FRAC_BITS:0]      in_pos,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hmc_pkg::CHAN_W-1:0]  red_level,
  output logic [hmc_pkg::CHAN_W-1:0]  green_level,
  output logic [hmc_pkg::CHAN_W-1:0]  blue_level
);

  localparam int FW = POS_FRAC_BITS;
  localparam int VW = FW + 3;
  localparam logic [VW-1:0] ONE = VW'(1) << FW;

  logic                c1_valid;
  logic                c1_ready;
  hmc_pkg::cls_t       c1_cls;
  logic [VW-1:0]       c1_pos6;
  logic                c2_valid;
  logic                c2_ready;
  hmc_pkg::cls_t       c2_cls;
  logic [FW:0]         c2_tri [hmc_pkg::NUM_TRI];
  logic                c3_ready;
  logic [FW:0]         tri_val [hmc_pkg::NUM_TRI];
  logic [VW-1:0]       sum_r;
  logic [VW-1:0]       sum_g;
  logic [VW-1:0]       sum_b;

  function automatic logic [FW:0] tri_height(input logic [VW-1:0] v, input logic [VW-1:0] c);
    logic [VW-1:0] d;
    d = (v >= c) ? (v - c) : (c - v);
    return (d < ONE) ? (FW+1)'(ONE - d) : '0;
  endfunction

  function automatic logic [hmc_pkg::CHAN_W-1:0] to_chan(input logic [VW-1:0] sum);
    logic [VW-1:0] s;
    s = sum >> (FW - 8);
    return (s > VW'(hmc_pkg::CHAN_MAX)) ? hmc_pkg::CHAN_MAX : s[hmc_pkg::CHAN_W-1:0];
  endfunction

  assign c3_ready = !out_valid || out_ready;
  assign c2_ready = !c2_valid || c3_ready;
  assign c1_ready = !c1_valid || c2_ready;
  assign in_ready = c1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid  <= 1'b0;
      c2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (c1_ready) c1_valid  <= in_valid;
      if (c2_ready) c2_valid  <= c1_valid;
      if (c3_ready) out_valid <= c2_valid;
    end
  end

  // Scale position by six: 4u + 2u
  always_ff @(posedge clk) begin
    if (c1_ready && in_valid) begin
      c1_cls  <= in_cls;
      c1_pos6 <= (VW'(in_pos) << 2) + (VW'(in_pos) << 1);
    end
  end

  always_comb begin
    for (int k = 0; k < hmc_pkg::NUM_TRI; k++) begin
      tri_val[k] = tri_height(c1_pos6, VW'(k + 1) << FW);
    end
  end

  always_ff @(posedge clk) begin
    if (c2_ready && c1_valid) begin
      c2_cls <= c1_cls;
      c2_tri <= tri_val;
    end
  end

  assign sum_r = VW'(c2_tri[hmc_pkg::TRI_YEL]) + VW'(c2_tri[hmc_pkg::TRI_RED])
               + VW'(c2_tri[hmc_pkg::TRI_WHITE]);
  assign sum_g = VW'(c2_tri[hmc_pkg::TRI_CYAN]) + VW'(c2_tri[hmc_pkg::TRI_GREEN])
               + VW'(c2_tri[hmc_pkg::TRI_YEL]) + VW'(c2_tri[hmc_pkg::TRI_WHITE]);
  assign sum_b = VW'(c2_tri[hmc_pkg::TRI_BLUE]) + VW'(c2_tri[hmc_pkg::TRI_CYAN])
               + VW'(c2_tri[hmc_pkg::TRI_WHITE]);

  // Output register; black wins over white
  always_ff @(posedge clk) begin
    if (c3_ready && c2_valid) begin
      if (c2_cls.below) begin
        red_level   <= hmc_pkg::CHAN_MIN;
        green_level <= hmc_pkg::CHAN_MIN;
        blue_level  <= hmc_pkg::CHAN_MIN;
      end else if (c2_cls.white) begin
        red_level   <= hmc_pkg::CHAN_MAX;
        green_level <= hmc_pkg::CHAN_MAX;
        blue_level  <= hmc_pkg::CHAN_MAX;
      end else begin
        red_level   <= to_chan(sum_r);
        green_level <= to_chan(sum_g);
        blue_level  <= to_chan(sum_b);
      end
    end
  end

endmodule

// ===== hdl/heatmap_color_mapper_unit.sv =====
`timescale 1ns / 1ps

// Heat map color mapper: turns a signed temperature (8 fraction bits) into
// an RGB triple on a black-blue-cyan-green-yellow-red-white scale.
//
// Channels: sample (sink) takes temp_sample, color (source) gives
// red_level, green_level and blue_level; an item moves when valid and ready
// are both high. min_temp and max_temp are set through the APB port at byte
// addresses 0 and 4; write them only while no item is in flight.
//
// The path runs through POS_FRAC_BITS + 6 register stages: input register,
// classify stage, one restoring-divider stage per quotient bit, then scale,
// triangle and channel stages. Throughput is one item per cycle while the
// receiver does not stall; each divider stage does one compare-subtract.
//
// Reset clears every valid bit and loads min_temp = 0, max_temp = 100.0.
// When the receiver stalls, each stage holds its item and the pipeline fills
// its empty slots; sample.ready drops only once every stage is occupied.
module heatmap_color_mapper_unit #(
  parameter int TEMP_WIDTH    = 24,
  parameter int POS_FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  hmc_sample_if.sink                     sample,
  hmc_color_if.source                    color,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hmc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [hmc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [hmc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  // Quotient u = floor((t - min) * 2^F / (max - min)) spans 0..2^F
  localparam int QW = POS_FRAC_BITS + 1;

  logic signed [TEMP_WIDTH-1:0] min_temp;
  logic signed [TEMP_WIDTH-1:0] max_temp;
  logic [TEMP_WIDTH-1:0]        span;
  logic                         empty;

  // Divider chain: index 0 is the front end's output, index QW the last stage
  logic                  dv_valid [QW+1];
  logic                  dv_ready [QW+1];
  hmc_pkg::cls_t         dv_cls   [QW+1];
  logic [TEMP_WIDTH-1:0] dv_rem   [QW+1];
  logic [QW-1:0]         dv_quo   [QW+1];

  hmc_cfg #(
    .TEMP_WIDTH (TEMP_WIDTH)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .min_temp (min_temp),
    .max_temp (max_temp),
    .span     (span),
    .empty    (empty)
  );

  // Register the sample, then classify it and form t - min
  hmc_front #(
    .TEMP_WIDTH (TEMP_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (sample.valid),
    .in_ready    (sample.ready),
    .temp_sample (sample.temp_sample),
    .min_temp    (min_temp),
    .max_temp    (max_temp),
    .empty       (empty),
    .out_valid   (dv_valid[0]),
    .out_ready   (dv_ready[0]),
    .out_cls     (dv_cls[0]),
    .out_diff    (dv_rem[0])
  );

  // Quotient bits shift in from the right; start from zero
  assign dv_quo[0] = '0;

  // One quotient bit per stage, most significant first
  for (genvar g = 0; g < QW; g++) begin : g_div
    hmc_div_stage #(
      .TEMP_WIDTH (TEMP_WIDTH),
      .QW         (QW),
      .FIRST      (g == 0)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv_valid[g]),
      .in_ready  (dv_ready[g]),
      .in_cls    (dv_cls[g]),
      .in_rem    (dv_rem[g]),
      .in_quo    (dv_quo[g]),
      .span      (span),
      .out_valid (dv_valid[g+1]),
      .out_ready (dv_ready[g+1]),
      .out_cls   (dv_cls[g+1]),
      .out_rem   (dv_rem[g+1]),
      .out_quo   (dv_quo[g+1])
    );
  end

  // Triangles, channel sums, clamp and the output register
  hmc_shade #(
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_shade (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (dv_valid[QW]),
    .in_ready    (dv_ready[QW]),
    .in_cls      (dv_cls[QW]),
    .in_pos      (dv_quo[QW]),
    .out_valid   (color.valid),
    .out_ready   (color.ready),
    .red_level   (color.red_level),
    .green_level (color.green_level),
    .blue_level  (color.blue_level)
  );

endmodule
